@@ hdl/msd_pkg.sv @@
`default_nettype none
package msd_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 4;
  localparam int HOLD_W       = 16;
  localparam int STEP_W       = 10;
  localparam int TABLE_W      = 64;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 64;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 16;

  localparam logic [HOLD_W-1:0]  INITIAL_THRESHOLD = 16'd50;
  localparam logic [HOLD_W-1:0]  HOLD_MAX          = 16'hFFFF;
  localparam logic [STEP_W-1:0]  TICK_STEP_RESET   = 10'd20;
  localparam logic [TABLE_W-1:0] HOLD_TABLE_RESET  = 64'h0032_0032_0032_0032;

  typedef enum logic [1:0] {
    REG_ON_HOLD  = 2'd0,
    REG_OFF_HOLD = 2'd1,
    REG_STEP     = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic level;
    logic accept;
    logic busy;
  } lane_res_t;

endpackage
`default_nettype wire

@@ hdl/msd_lane.sv @@
`default_nettype none
module msd_lane (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      fire,
  input  wire logic                      prime,
  input  wire logic                      sample,
  input  wire logic [msd_pkg::STEP_W-1:0] step,
  input  wire logic [msd_pkg::HOLD_W-1:0] on_hold,
  input  wire logic [msd_pkg::HOLD_W-1:0] off_hold,
  output msd_pkg::lane_res_t             res
);
  import msd_pkg::*;

  logic              active, active_next;
  logic              passed, passed_next;
  logic              stable, stable_next;
  logic [HOLD_W-1:0] hold, hold_next;
  logic [HOLD_W-1:0] threshold, threshold_next;

  logic              cur_stable;
  logic              changed;
  logic [HOLD_W:0]   sum;
  logic [HOLD_W-1:0] hold_sat;
  logic              hit;

  always_comb begin
    cur_stable     = prime ? ~sample : stable;
    changed        = !passed && (cur_stable != sample);
    sum            = {1'b0, hold} + {{(HOLD_W + 1 - STEP_W){1'b0}}, step};
    hold_sat       = sum[HOLD_W] ? HOLD_MAX : sum[HOLD_W-1:0];
    hit            = 1'b0;
    active_next    = active;
    passed_next    = passed;
    stable_next    = cur_stable;
    hold_next      = hold;
    threshold_next = threshold;
    if (!active) begin
      if (changed) begin
        active_next = 1'b1;
        hold_next   = '0;
      end
    end else if (changed) begin
      hold_next = hold_sat;
      if (hold_sat >= threshold) begin
        hit            = 1'b1;
        passed_next    = 1'b1;
        stable_next    = ~cur_stable;
        threshold_next = cur_stable ? off_hold : on_hold;
      end
    end else begin
      active_next = 1'b0;
      passed_next = 1'b0;
    end
    res.level  = stable_next;
    res.accept = hit;
    res.busy   = active || changed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      passed    <= 1'b0;
      stable    <= 1'b0;
      hold      <= '0;
      threshold <= INITIAL_THRESHOLD;
    end else if (fire) begin
      active    <= active_next;
      passed    <= passed_next;
      stable    <= stable_next;
      hold      <= hold_next;
      threshold <= threshold_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/msd_merge.sv @@
`default_nettype none
module msd_merge (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire msd_pkg::lane_res_t            res [msd_pkg::NUM_CHANNELS],
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [msd_pkg::OUT_TDATA_W-1:0]    out_data
);
  import msd_pkg::*;

  logic [CH_W-1:0] levels;
  logic [CH_W-1:0] mask;
  logic [NUM_CHANNELS-1:0] busy;

  for (genvar g = 0; g < CH_W; g++) begin : g_pack
    if (g < NUM_CHANNELS) begin : g_used
      assign levels[g] = res[g].level;
      assign mask[g]   = res[g].accept;
      assign busy[g]   = res[g].busy;
    end else begin : g_unused
      assign levels[g] = 1'b0;
      assign mask[g]   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= {{(OUT_TDATA_W - 2 * CH_W - 1){1'b0}}, ~(|busy), mask, levels};
    end
  end

endmodule
`default_nettype wire

@@ hdl/multi_channel_switch_debouncer_unit.sv @@
// four-channel switch debouncer with separate on and off hold times
// s_* channel: one transaction per poll tick, tdata[3:0] holds the raw line levels
// m_* channel: one transaction per tick, tdata[3:0] accepted levels,
//   tdata[7:4] channels that accepted a change on this tick, tdata[8] all idle
// apb port: 0x00 on hold table, 0x08 off hold table, 0x10 tick step;
//   each table holds four 16-bit hold times, channel i in bits 16i+15..16i
// the result is registered and appears in the cycle after the tick is taken
// throughput: one tick per cycle while the receiver does not stall; every lane updates its state
//   on each tick with a 17-bit add and a 16-bit compare
// s_tready is high while the output register is empty or being drained,
//   so a stalled receiver holds one result and stops further ticks
// reset: all channels idle, thresholds 50, tables and step at their defaults;
//   the first tick loads every accepted level with the inverted sample
`default_nettype none
module multi_channel_switch_debouncer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [msd_pkg::IN_TDATA_W-1:0]  s_tdata,   // sampled_levels
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [msd_pkg::OUT_TDATA_W-1:0]      m_tdata,   // accepted_levels, accepted_mask, all_idle
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [msd_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [msd_pkg::DATA_W-1:0]      pwdata,
  output logic [msd_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);
  import msd_pkg::*;

  logic [TABLE_W-1:0] on_hold_table;
  logic [TABLE_W-1:0] off_hold_table;
  logic [STEP_W-1:0]  tick_step;
  logic               primed;
  logic               fire;
  logic               wr_en;
  reg_idx_t           idx;
  lane_res_t          res [NUM_CHANNELS];

  assign pready   = 1'b1;
  assign idx      = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en    = psel && penable && pwrite && pready;
  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_hold_table  <= HOLD_TABLE_RESET;
      off_hold_table <= HOLD_TABLE_RESET;
      tick_step      <= TICK_STEP_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_ON_HOLD:  on_hold_table  <= pwdata;
        REG_OFF_HOLD: off_hold_table <= pwdata;
        REG_STEP:     tick_step      <= pwdata[STEP_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ON_HOLD:  prdata = on_hold_table;
      REG_OFF_HOLD: prdata = off_hold_table;
      REG_STEP:     prdata = {{(DATA_W - STEP_W){1'b0}}, tick_step};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (fire) begin
      primed <= 1'b1;
    end
  end

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
    msd_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .fire     (fire),
      .prime    (!primed),
      .sample   (s_tdata[g]),
      .step     (tick_step),
      .on_hold  (on_hold_table[HOLD_W*g +: HOLD_W]),
      .off_hold (off_hold_table[HOLD_W*g +: HOLD_W]),
      .res      (res[g])
    );
  end

  msd_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res       (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire
